### rtl/tlbpt_pkg.sv
`default_nettype none
package tlbpt_pkg;

  // Sizes of the translator.
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_W    = 8;
  localparam int FRAME_W     = 8;
  localparam int COUNT_W     = 16;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int TLB_CNT_W   = $clog2(TLB_ENTRIES + 1);
  localparam int FREE_W      = FRAME_W + 1;

  // The free-frame pointer stops here.
  localparam logic [FREE_W-1:0]  FRAME_LIMIT = FREE_W'(1 << FRAME_W);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // Result of a TLB lookup, valid in the cycle after the lookup is issued.
  typedef struct packed {
    logic                 hit;
    logic [TLB_IDX_W-1:0] pos;
    logic [FRAME_W-1:0]   frame;
  } lookup_t;

  // Update of the TLB when a translation completes.
  typedef struct packed {
    logic                 en;
    logic                 hit;
    logic [TLB_IDX_W-1:0] pos;
    logic [PAGE_W-1:0]    page;
    logic [FRAME_W-1:0]   frame;
  } update_t;

  // Control states of the translator.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

endpackage
`default_nettype wire

### rtl/tlbpt_if.sv
`default_nettype none
// Request channel: one logical address per word.
interface tlbpt_req_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpt_pkg::ADDR_W-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

// Response channel: one translation result per word.
interface tlbpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tlbpt_pkg::ADDR_W-1:0]  physical_address;
  logic                          tlb_hit;
  logic                          page_fault;
  logic [tlbpt_pkg::COUNT_W-1:0] hit_total;
  logic [tlbpt_pkg::COUNT_W-1:0] fault_total;

  modport source (output valid, output physical_address, output tlb_hit, output page_fault,
                  output hit_total, output fault_total, input ready);
  modport sink (input valid, input physical_address, input tlb_hit, input page_fault,
                input hit_total, input fault_total, output ready);
endinterface
`default_nettype wire

### rtl/tlb_page_table_translator_top.sv
`default_nettype none
// Demand-paging address translator. Each request word carries a 16-bit
// logical address: page number in the upper byte, offset in the lower byte.
// The page is looked up in a 16-entry fully associative TLB kept in age
// order; on a miss the direct-mapped page table (a 256-entry frame RAM plus
// valid flags cleared by reset) is used, and an unmapped page gets the next
// free frame. The page is then moved to or inserted at the TLB tail,
// evicting the oldest entry when the TLB is full. Each response word gives
// the physical address, hit and fault flags and saturating hit and fault
// totals. When an address is accepted the page-table RAM read and TLB tag
// compare are registered; in ST_LOOK the frame is resolved and the page
// table and TLB are written back. A new address is taken only after that
// commit, so the block never accepts one while the last is unfinished. A
// finished response sits in an output register, and the block accepts the
// next address while it waits there.
module tlb_page_table_translator_top (
  input wire logic    clk,
  input wire logic    rst,
  tlbpt_req_if.sink   req,
  tlbpt_rsp_if.source rsp
);

  tlbpt_pkg::state_t                state;
  tlbpt_pkg::state_t                state_next;
  logic [tlbpt_pkg::PAGE_W-1:0]     page;
  logic [tlbpt_pkg::OFFSET_W-1:0]   offset;
  logic [tlbpt_pkg::PAGE_W-1:0]     req_page;
  logic [tlbpt_pkg::PAGE_COUNT-1:0] page_valid;
  logic [tlbpt_pkg::FREE_W-1:0]     next_free_frame;
  logic [tlbpt_pkg::COUNT_W-1:0]    hit_counter;
  logic [tlbpt_pkg::COUNT_W-1:0]    fault_counter;
  logic [tlbpt_pkg::COUNT_W-1:0]    hit_counter_next;
  logic [tlbpt_pkg::COUNT_W-1:0]    fault_counter_next;
  logic [tlbpt_pkg::FRAME_W-1:0]    table_frame;
  logic [tlbpt_pkg::FRAME_W-1:0]    frame;
  logic                             accept;
  logic                             commit;
  logic                             fault;
  logic                             out_valid;
  tlbpt_pkg::lookup_t               lookup;
  tlbpt_pkg::update_t               update;

  assign req_page = req.logical_address[tlbpt_pkg::OFFSET_W +: tlbpt_pkg::PAGE_W];
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == tlbpt_pkg::ST_IDLE);

  // The result is committed once the output register is free or emptying.
  assign commit = (state == tlbpt_pkg::ST_LOOK) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      tlbpt_pkg::ST_IDLE: if (accept) state_next = tlbpt_pkg::ST_LOOK;
      tlbpt_pkg::ST_LOOK: if (commit) state_next = tlbpt_pkg::ST_IDLE;
      default:            state_next = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted address.
  always_ff @(posedge clk) begin
    if (accept) begin
      page   <= req_page;
      offset <= req.logical_address[tlbpt_pkg::OFFSET_W-1:0];
    end
  end

  // Page-table frame store; read at accept, written back on a fault.
  tlbpt_ram #(
    .WIDTH(tlbpt_pkg::FRAME_W),
    .DEPTH(tlbpt_pkg::PAGE_COUNT)
  ) u_page_frame (
    .clk    (clk),
    .wr_en  (commit && fault),
    .wr_addr(page),
    .wr_data(frame),
    .rd_en  (accept),
    .rd_addr(req_page),
    .rd_data(table_frame)
  );

  tlbpt_tlb u_tlb (
    .clk        (clk),
    .rst        (rst),
    .lookup_en  (accept),
    .lookup_page(req_page),
    .lookup     (lookup),
    .update     (update)
  );

  // Resolve the frame: TLB first, then the page table, else allocate.
  always_comb begin
    fault = !lookup.hit && !page_valid[page];
    if (lookup.hit) begin
      frame = lookup.frame;
    end else if (page_valid[page]) begin
      frame = table_frame;
    end else begin
      frame = next_free_frame[tlbpt_pkg::FRAME_W-1:0];
    end
    update.en    = commit;
    update.hit   = lookup.hit;
    update.pos   = lookup.pos;
    update.page  = page;
    update.frame = frame;
    hit_counter_next = (lookup.hit && hit_counter != tlbpt_pkg::COUNT_MAX) ?
                       hit_counter + 1'b1 : hit_counter;
    fault_counter_next = (fault && fault_counter != tlbpt_pkg::COUNT_MAX) ?
                         fault_counter + 1'b1 : fault_counter;
  end

  // Page-table valid flags, free-frame pointer and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid      <= '0;
      next_free_frame <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
    end else if (commit) begin
      hit_counter   <= hit_counter_next;
      fault_counter <= fault_counter_next;
      if (fault) begin
        page_valid[page] <= 1'b1;
        if (next_free_frame < tlbpt_pkg::FRAME_LIMIT) begin
          next_free_frame <= next_free_frame + 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.physical_address <= {frame, offset};
      rsp.tlb_hit          <= lookup.hit;
      rsp.page_fault       <= fault;
      rsp.hit_total        <= hit_counter_next;
      rsp.fault_total      <= fault_counter_next;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

### rtl/tlbpt_ram.sv
`default_nettype none
// Single-port-write, single-port-read RAM with a registered read.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/tlbpt_tlb.sv
`default_nettype none
// Fully associative TLB kept in age order: entry 0 is the oldest, the
// entry just below the fill count is the most recent.
module tlbpt_tlb (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           lookup_en,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0]   lookup_page,
  output tlbpt_pkg::lookup_t                  lookup,
  input  wire tlbpt_pkg::update_t             update
);

  localparam int N = tlbpt_pkg::TLB_ENTRIES;

  logic [tlbpt_pkg::PAGE_W-1:0]    tlb_page  [N];
  logic [tlbpt_pkg::FRAME_W-1:0]   tlb_frame [N];
  logic [tlbpt_pkg::PAGE_W-1:0]    up_page   [N];
  logic [tlbpt_pkg::FRAME_W-1:0]   up_frame  [N];
  logic [tlbpt_pkg::TLB_CNT_W-1:0] fill;
  logic [tlbpt_pkg::TLB_CNT_W-1:0] fill_next;
  logic [N-1:0]                    match;
  logic [N-1:0]                    match_next;
  logic                            full;
  logic                            shift_en;
  logic [tlbpt_pkg::TLB_CNT_W-1:0] rm_pos;
  logic [tlbpt_pkg::TLB_CNT_W-1:0] tail;

  // Tag compare against the valid entries, registered for the next cycle.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_next[i] = (tlb_page[i] == lookup_page) &&
                      (tlbpt_pkg::TLB_CNT_W'(i) < fill);
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      match <= match_next;
    end
  end

  // The oldest matching entry wins.
  always_comb begin
    lookup.hit = 1'b0;
    lookup.pos = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup.hit = 1'b1;
        lookup.pos = tlbpt_pkg::TLB_IDX_W'(i);
      end
    end
    lookup.frame = tlb_frame[lookup.pos];
  end

  // Each entry's younger neighbor, used when entries move toward the head.
  for (genvar g = 0; g < N; g++) begin : g_up
    if (g < N - 1) begin : g_mid
      assign up_page[g]  = tlb_page[g + 1];
      assign up_frame[g] = tlb_frame[g + 1];
    end else begin : g_last
      assign up_page[g]  = tlb_page[g];
      assign up_frame[g] = tlb_frame[g];
    end
  end

  // A hit removes its entry, a miss on a full TLB removes the oldest;
  // the translated page always lands at the tail.
  always_comb begin
    full      = (fill == tlbpt_pkg::TLB_CNT_W'(N));
    shift_en  = update.hit || full;
    rm_pos    = update.hit ? tlbpt_pkg::TLB_CNT_W'(update.pos) : '0;
    if (update.hit) begin
      tail = fill - 1'b1;
    end else if (full) begin
      tail = tlbpt_pkg::TLB_CNT_W'(N - 1);
    end else begin
      tail = fill;
    end
    fill_next = shift_en ? fill : fill + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (update.en) begin
      for (int i = 0; i < N; i++) begin
        if (tlbpt_pkg::TLB_CNT_W'(i) == tail) begin
          tlb_page[i]  <= update.page;
          tlb_frame[i] <= update.frame;
        end else if (shift_en && tlbpt_pkg::TLB_CNT_W'(i) >= rm_pos &&
                     tlbpt_pkg::TLB_CNT_W'(i) < tail) begin
          tlb_page[i]  <= up_page[i];
          tlb_frame[i] <= up_frame[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (update.en) begin
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

### rtl/tlbpt_checker.sv
`default_nettype none
// Port-level checks of the translator.
module tlbpt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
  input wire logic                          tlb_hit,
  input wire logic                          page_fault,
  input wire logic [tlbpt_pkg::COUNT_W-1:0] hit_total,
  input wire logic [tlbpt_pkg::COUNT_W-1:0] fault_total
);

  // An accepted address keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted in back-to-back cycles");

  // A word is either a TLB hit or a fault, never both.
  a_hit_fault_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(tlb_hit && page_fault))
    else $error("hit and fault reported together");

  // A flagged event is counted in its own totals.
  a_totals_count_event: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!tlb_hit || hit_total != '0) && (!page_fault || fault_total != '0))
    else $error("event missing from its total");

  // A stalled response stays valid and holds its address and totals.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(physical_address) &&
                                $stable(hit_total) && $stable(fault_total))
    else $error("stalled response changed");

endmodule

bind tlb_page_table_translator_top tlbpt_checker u_tlbpt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .physical_address(rsp.physical_address),
  .tlb_hit         (rsp.tlb_hit),
  .page_fault      (rsp.page_fault),
  .hit_total       (rsp.hit_total),
  .fault_total     (rsp.fault_total)
);
`default_nettype wire

### test/tb_tlb_page_table_translator_top.sv
`default_nettype none
module tb_tlb_page_table_translator_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limit in cycles, well above the slowest correct run.
  localparam int CYCLE_LIMIT = 300_000;
  localparam int RANDOM_WORDS = 1865;
  localparam int FULL_RATE_WORDS = 60;
  localparam int MAX_PRINTED = 40;

  // One expected translation result.
  typedef struct packed {
    logic [tlbpt_pkg::ADDR_W-1:0]  phys;
    logic                          hit;
    logic                          fault;
    logic [tlbpt_pkg::COUNT_W-1:0] hits;
    logic [tlbpt_pkg::COUNT_W-1:0] faults;
  } xlat_t;

  // Ways the response side applies back-pressure.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  tlbpt_req_if req_ch ();
  tlbpt_rsp_if rsp_ch ();

  tlb_page_table_translator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the translator state.
  logic                          mapped    [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::FRAME_W-1:0] frame_map [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::PAGE_W-1:0]  tlb_tag   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0] tlb_frm   [tlbpt_pkg::TLB_ENTRIES];
  int                            tlb_used;
  int                            free_frame;
  int                            hit_count;
  int                            fault_count;

  xlat_t    pending_xlat[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       pacing_on = 1'b1;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_phase = 0;

  // Drop one TLB entry, moving younger entries toward the head.
  function automatic void tlb_drop(input int pos);
    for (int i = pos; i + 1 < tlb_used; i++) begin
      tlb_tag[i] = tlb_tag[i + 1];
      tlb_frm[i] = tlb_frm[i + 1];
    end
    tlb_used--;
  endfunction

  // Translate one address and advance the shadow state.
  function automatic xlat_t predict_translation(input logic [tlbpt_pkg::ADDR_W-1:0] addr);
    xlat_t                         res;
    logic [tlbpt_pkg::PAGE_W-1:0]  page;
    logic [tlbpt_pkg::FRAME_W-1:0] frame;
    int                            pos;
    bit                            found;
    page  = addr[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
    frame = '0;
    pos   = 0;
    found = 1'b0;
    res   = '0;
    for (int i = 0; i < tlb_used; i++) begin
      if (!found && tlb_tag[i] == page) begin
        found = 1'b1;
        pos   = i;
        frame = tlb_frm[i];
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (hit_count < tlbpt_pkg::COUNT_MAX) hit_count++;
      tlb_drop(pos);
    end else if (mapped[page]) begin
      frame = frame_map[page];
    end else begin
      res.fault = 1'b1;
      if (fault_count < tlbpt_pkg::COUNT_MAX) fault_count++;
      frame           = free_frame[tlbpt_pkg::FRAME_W-1:0];
      frame_map[page] = frame;
      mapped[page]    = 1'b1;
      if (free_frame < tlbpt_pkg::FRAME_LIMIT) free_frame++;
    end
    // The page always lands at the TLB tail.
    if (tlb_used >= tlbpt_pkg::TLB_ENTRIES) tlb_drop(0);
    tlb_tag[tlb_used] = page;
    tlb_frm[tlb_used] = frame;
    tlb_used++;
    res.phys   = {frame, addr[tlbpt_pkg::OFFSET_W-1:0]};
    res.hits   = hit_count[tlbpt_pkg::COUNT_W-1:0];
    res.faults = fault_count[tlbpt_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Send one address word; bursts are broken by random gaps while pacing is on.
  task automatic send_address(input logic [tlbpt_pkg::ADDR_W-1:0] addr);
    if (pacing_on && burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 20);
    end
    req_ch.valid           <= 1'b1;
    req_ch.logical_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_xlat.push_back(predict_translation(addr));
    if (burst_left > 0) burst_left--;
  endtask

  // Extreme addresses: first and last page, first and last offset.
  task automatic test_extremes();
    send_address(16'h0000);
    send_address(16'hFFFF);
    send_address(16'h00FF);
    send_address(16'hFF00);
  endtask

  // A hit on a middle entry moves it to the tail.
  task automatic test_tlb_reorder();
    send_address(16'h0137);
    send_address(16'h02C8);
    send_address(16'h0155);
  endtask

  // Sixteen new pages push out every older entry; the old pages then
  // translate through the page table without a fault.
  task automatic test_eviction();
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      send_address({8'h10 + 8'(i), 8'($urandom_range(0, 255))});
    end
    send_address(16'h0080);
    send_address(16'hFF7F);
  endtask

  // Random traffic: mostly a drifting hot set of pages, some scattered pages.
  task automatic test_random_traffic();
    logic [7:0] hot_base;
    int         hot_span;
    int         pick;
    logic [7:0] page;
    hot_base = 8'($urandom_range(0, 255));
    hot_span = 12;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 120 == 0) begin
        hot_base = 8'($urandom_range(0, 255));
        hot_span = $urandom_range(4, 24);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        page = hot_base + 8'($urandom_range(0, hot_span - 1));
      end else begin
        page = 8'($urandom_range(0, 255));
      end
      send_address({page, 8'($urandom_range(0, 255))});
    end
  endtask

  // Words back to back with an open response side, alternating two pages.
  task automatic test_full_rate();
    pacing_on = 1'b0;
    for (int n = 0; n < FULL_RATE_WORDS; n++) begin
      send_address({(n % 2 == 0) ? 8'h5A : 8'hA5, 8'(n)});
    end
    pacing_on = 1'b1;
  endtask

  // Reset, shadow state and the test sequence.
  initial begin
    for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++) begin
      mapped[i]    = 1'b0;
      frame_map[i] = '0;
    end
    tlb_used    = 0;
    free_frame  = 0;
    hit_count   = 0;
    fault_count = 0;
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.logical_address <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_tlb_reorder();
    test_eviction();
    test_random_traffic();
    test_full_rate();
    req_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Response side back-pressure, switching between patterns.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      rx_phase = (rx_phase == 2) ? 0 : rx_phase + 1;
      if (!pacing_on) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:     rsp_ch.ready <= 1'b1;
          RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: rsp_ch.ready <= (rx_phase == 0);
          default:     rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    xlat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_xlat.size() == 0) begin
        report_mismatch("unexpected word", 32'(rsp_ch.physical_address), 32'h0);
      end else begin
        want = pending_xlat.pop_front();
        if (rsp_ch.physical_address !== want.phys)
          report_mismatch("physical_address", 32'(rsp_ch.physical_address), 32'(want.phys));
        if (rsp_ch.tlb_hit !== want.hit)
          report_mismatch("tlb_hit", 32'(rsp_ch.tlb_hit), 32'(want.hit));
        if (rsp_ch.page_fault !== want.fault)
          report_mismatch("page_fault", 32'(rsp_ch.page_fault), 32'(want.fault));
        if (rsp_ch.hit_total !== want.hits)
          report_mismatch("hit_total", 32'(rsp_ch.hit_total), 32'(want.hits));
        if (rsp_ch.fault_total !== want.faults)
          report_mismatch("fault_total", 32'(rsp_ch.fault_total), 32'(want.faults));
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire
